[rtl/assert_macros.svh]
// Assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptd_pkg.sv]
// Shared types, constants and control word layout of the task dispatcher
`default_nettype none

package ptd_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W      = 8;
    localparam int PERIOD_W  = 31;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 32;
    localparam int STEP_W    = 20;
    localparam int TICKS_W   = 32;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [STEP_W-1:0] TIME_STEP_RESET = STEP_W'(1000);
    localparam logic [PADDR_W-3:0] REG_TIME_STEP  = '0;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_REGISTER  = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_RESET_ALL = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]   last_time;
        logic [ID_W-1:0]     ident;
        logic [PRIO_W-1:0]   prio;
        logic [PERIOD_W-1:0] period;
    } entry_t;

    typedef struct packed {
        logic                fired;
        logic [ID_W-1:0]     task_out;
        logic                last_of_run;
        logic                status;
        logic [TICKS_W-1:0]  ticks_done;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_INIT,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_END,
        S_REG_INIT,
        S_REG_RD,
        S_REG_CMP,
        S_REG_INS,
        S_REG_FULL,
        S_CLEAR,
        S_RESET_ALL
    } step_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_FULL,
        J_PTR_ZERO,
        J_PTR_END,
        J_PRIO_LESS
    } jmp_cond_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_INC,
        PTR_DEC_LESS
    } ptr_op_t;

    typedef enum logic {
        RD_PTR,
        RD_PTR_M1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_STAMP,
        WR_MOVE,
        WR_INSERT
    } wr_op_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_PEND,
        EM_FINAL,
        EM_REG_OK,
        EM_REG_FULL,
        EM_CLEAR,
        EM_RESET
    } emit_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_CLEAR
    } cnt_op_t;

    typedef enum logic [1:0] {
        TM_HOLD,
        TM_ADVANCE,
        TM_ZERO
    } time_op_t;

    typedef struct packed {
        jmp_cond_t cond;
        step_t     target;
        logic      done;
        ptr_op_t   ptr_op;
        logic      rd_en;
        rd_sel_t   rd_sel;
        wr_op_t    wr_op;
        emit_t     emit;
        cnt_op_t   cnt_op;
        time_op_t  time_op;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic ptr_zero;
        logic ptr_end;
        logic prio_less;
        logic slot_free;
    } flags_t;

    localparam ctl_t CTL_NOP = '{
        cond:    J_NEXT,
        target:  S_IDLE,
        done:    1'b0,
        ptr_op:  PTR_HOLD,
        rd_en:   1'b0,
        rd_sel:  RD_PTR,
        wr_op:   WR_NONE,
        emit:    EM_NONE,
        cnt_op:  CNT_HOLD,
        time_op: TM_HOLD
    };

endpackage

`default_nettype wire

[rtl/ptd_regs.sv]
// Configuration register file with APB-style access
`default_nettype none

module ptd_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ptd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ptd_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [ptd_pkg::STEP_W-1:0]    time_step
);
    import ptd_pkg::*;

    logic [STEP_W-1:0]   time_step_reg;
    logic [PADDR_W-3:0]  reg_index;
    logic                wr_fire;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_fire   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (wr_fire && (reg_index == REG_TIME_STEP))
        begin
            time_step_reg <= pwdata[STEP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_TIME_STEP)
        begin
            prdata = {{(PDATA_W-STEP_W){1'b0}}, time_step_reg};
        end
    end

    assign time_step = time_step_reg;

endmodule

`default_nettype wire

[rtl/ptd_seq.sv]
// Microcode sequencer: step counter, control store and jump logic
`default_nettype none

module ptd_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ptd_pkg::cmd_t   cmd,
    input  wire ptd_pkg::flags_t flags,
    output logic                 in_ready,
    output ptd_pkg::ctl_t        ctl,
    output logic                 go
);
    import ptd_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    step_t entry;
    logic  take;

    function automatic ctl_t ucode(input step_t s);
        ctl_t w;
        w = CTL_NOP;
        unique case (s)
            S_IDLE:
            begin
            end
            S_TICK_INIT:
            begin
                w.ptr_op = PTR_ZERO;
            end
            S_TICK_RD:
            begin
                w.cond   = J_PTR_END;
                w.target = S_TICK_END;
                w.rd_en  = 1'b1;
                w.rd_sel = RD_PTR;
            end
            S_TICK_EVAL:
            begin
                w.cond   = J_ALWAYS;
                w.target = S_TICK_RD;
                w.ptr_op = PTR_INC;
                w.wr_op  = WR_STAMP;
                w.emit   = EM_PEND;
            end
            S_TICK_END:
            begin
                w.done    = 1'b1;
                w.emit    = EM_FINAL;
                w.time_op = TM_ADVANCE;
            end
            S_REG_INIT:
            begin
                w.cond   = J_FULL;
                w.target = S_REG_FULL;
                w.ptr_op = PTR_COUNT;
            end
            S_REG_RD:
            begin
                w.cond   = J_PTR_ZERO;
                w.target = S_REG_INS;
                w.rd_en  = 1'b1;
                w.rd_sel = RD_PTR_M1;
            end
            S_REG_CMP:
            begin
                w.cond   = J_PRIO_LESS;
                w.target = S_REG_RD;
                w.ptr_op = PTR_DEC_LESS;
                w.wr_op  = WR_MOVE;
            end
            S_REG_INS:
            begin
                w.done   = 1'b1;
                w.wr_op  = WR_INSERT;
                w.cnt_op = CNT_INC;
                w.emit   = EM_REG_OK;
            end
            S_REG_FULL:
            begin
                w.done = 1'b1;
                w.emit = EM_REG_FULL;
            end
            S_CLEAR:
            begin
                w.done   = 1'b1;
                w.cnt_op = CNT_CLEAR;
                w.emit   = EM_CLEAR;
            end
            S_RESET_ALL:
            begin
                w.done    = 1'b1;
                w.cnt_op  = CNT_CLEAR;
                w.time_op = TM_ZERO;
                w.emit    = EM_RESET;
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    assign ctl      = ucode(pc_reg);
    assign go       = (ctl.emit == EM_NONE) || flags.slot_free;
    assign in_ready = (pc_reg == S_IDLE);

    always_comb
    begin
        unique case (cmd)
            CMD_TICK:      entry = S_TICK_INIT;
            CMD_REGISTER:  entry = S_REG_INIT;
            CMD_CLEAR:     entry = S_CLEAR;
            CMD_RESET_ALL: entry = S_RESET_ALL;
        endcase
    end

    always_comb
    begin
        unique case (ctl.cond)
            J_NEXT:      take = 1'b0;
            J_ALWAYS:    take = 1'b1;
            J_FULL:      take = flags.full;
            J_PTR_ZERO:  take = flags.ptr_zero;
            J_PTR_END:   take = flags.ptr_end;
            J_PRIO_LESS: take = flags.prio_less;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (pc_reg == S_IDLE)
        begin
            if (in_valid)
            begin
                pc_next = entry;
            end
        end
        else if (go)
        begin
            if (ctl.done)
            begin
                pc_next = S_IDLE;
            end
            else if (take)
            begin
                pc_next = ctl.target;
            end
            else
            begin
                pc_next = step_t'(pc_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ptd_dp.sv]
// Datapath: task table, pointers, scheduler time, tick count and result register
`default_nettype none

module ptd_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [ptd_pkg::ID_W-1:0]       in_id,
    input  wire logic [ptd_pkg::PERIOD_W-1:0]   in_period,
    input  wire logic [ptd_pkg::PRIO_W-1:0]     in_prio,
    input  wire logic [ptd_pkg::STEP_W-1:0]     time_step,
    input  wire ptd_pkg::ctl_t                  ctl,
    input  wire logic                           go,
    output ptd_pkg::flags_t                     flags,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ptd_pkg::res_t                       res
);
    import ptd_pkg::*;

    entry_t                mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]  fired_reg;
    entry_t                rd_reg;
    logic                  rd_fired_reg;

    logic [CNT_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TICKS_W-1:0]    tick_reg;
    logic                  pend_valid_reg;
    logic [ID_W-1:0]       pend_id_reg;
    logic [ID_W-1:0]       id_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [PRIO_W-1:0]     prio_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;

    logic [CNT_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [TIME_W-1:0]     elapsed;
    logic                  due;
    logic                  prio_less;
    logic                  wr_en;
    entry_t                wr_data;
    logic                  wr_fired;
    logic                  emit_en;
    res_t                  res_next;
    logic [TICKS_W-1:0]    tick_inc;

    assign rd_addr   = (ctl.rd_sel == RD_PTR_M1) ? (ptr_reg - CNT_W'(1)) : ptr_reg;
    assign rd_idx    = rd_addr[IDX_W-1:0];
    assign wr_idx    = ptr_reg[IDX_W-1:0];
    assign elapsed   = now_reg - rd_reg.last_time;
    assign due       = !rd_fired_reg || (elapsed >= {1'b0, rd_reg.period});
    assign prio_less = (rd_reg.prio < prio_reg);
    assign tick_inc  = tick_reg + TICKS_W'(1);

    assign flags.full      = (count_reg == CNT_W'(MAX_TASKS));
    assign flags.ptr_zero  = (ptr_reg == '0);
    assign flags.ptr_end   = (ptr_reg == count_reg);
    assign flags.prio_less = prio_less;
    assign flags.slot_free = !out_valid_reg || res_ready;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_data  = rd_reg;
        wr_fired = rd_fired_reg;
        unique case (ctl.wr_op)
            WR_NONE:
            begin
            end
            WR_STAMP:
            begin
                wr_en             = due;
                wr_data.last_time = now_reg;
                wr_fired          = 1'b1;
            end
            WR_MOVE:
            begin
                wr_en = prio_less;
            end
            WR_INSERT:
            begin
                wr_en     = 1'b1;
                wr_data   = '{last_time: '0, ident: id_reg, prio: prio_reg,
                              period: period_reg};
                wr_fired  = 1'b0;
            end
        endcase
        wr_en = wr_en && go;
    end

    always_comb
    begin
        emit_en  = 1'b0;
        res_next = '{fired: 1'b0, task_out: '0, last_of_run: 1'b1, status: 1'b0,
                     ticks_done: tick_reg};
        unique case (ctl.emit)
            EM_NONE:
            begin
            end
            EM_PEND:
            begin
                emit_en              = due && pend_valid_reg;
                res_next.fired       = 1'b1;
                res_next.task_out    = pend_id_reg;
                res_next.last_of_run = 1'b0;
                res_next.ticks_done  = tick_inc;
            end
            EM_FINAL:
            begin
                emit_en             = 1'b1;
                res_next.fired      = pend_valid_reg;
                res_next.task_out   = pend_valid_reg ? pend_id_reg : '0;
                res_next.ticks_done = tick_inc;
            end
            EM_REG_OK:
            begin
                emit_en           = 1'b1;
                res_next.task_out = id_reg;
            end
            EM_REG_FULL:
            begin
                emit_en           = 1'b1;
                res_next.task_out = id_reg;
                res_next.status   = 1'b1;
            end
            EM_CLEAR:
            begin
                emit_en = 1'b1;
            end
            EM_RESET:
            begin
                emit_en             = 1'b1;
                res_next.ticks_done = '0;
            end
            default:
            begin
            end
        endcase
        emit_en = emit_en && go;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en && go)
        begin
            rd_reg       <= mem[rd_idx];
            rd_fired_reg <= fired_reg[rd_idx];
        end
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (accept)
        begin
            id_reg     <= in_id;
            period_reg <= in_period;
            prio_reg   <= in_prio;
        end
        if (go && (ctl.emit == EM_PEND) && due)
        begin
            pend_id_reg <= rd_reg.ident;
        end
        if (emit_en)
        begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fired_reg      <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            now_reg        <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (go && (ctl.cnt_op == CNT_CLEAR))
            begin
                fired_reg <= '0;
            end
            else if (wr_en)
            begin
                fired_reg[wr_idx] <= wr_fired;
            end

            if (go)
            begin
                unique case (ctl.ptr_op)
                    PTR_HOLD:     ptr_reg <= ptr_reg;
                    PTR_ZERO:     ptr_reg <= '0;
                    PTR_COUNT:    ptr_reg <= count_reg;
                    PTR_INC:      ptr_reg <= ptr_reg + CNT_W'(1);
                    PTR_DEC_LESS: ptr_reg <= prio_less ? (ptr_reg - CNT_W'(1)) : ptr_reg;
                    default:      ptr_reg <= ptr_reg;
                endcase

                unique case (ctl.cnt_op)
                    CNT_HOLD:  count_reg <= count_reg;
                    CNT_INC:   count_reg <= count_reg + CNT_W'(1);
                    CNT_CLEAR: count_reg <= '0;
                    default:   count_reg <= count_reg;
                endcase

                unique case (ctl.time_op)
                    TM_HOLD:
                    begin
                    end
                    TM_ADVANCE:
                    begin
                        now_reg  <= now_reg + {{(TIME_W-STEP_W){1'b0}}, time_step};
                        tick_reg <= tick_inc;
                    end
                    TM_ZERO:
                    begin
                        now_reg  <= '0;
                        tick_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase

                if ((ctl.emit == EM_PEND) && due)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else if (ctl.emit == EM_FINAL)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end

            if (emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

[rtl/periodic_task_dispatcher_core.sv]
// Top level of the priority periodic task dispatcher
//
//  channel  side    handshake                    word
//  s_*      input   s_tvalid/s_tready            tuser: command; tdata: id, period, priority
//  m_*      output  m_tvalid/m_tready, m_tlast   tuser: fired, status; tdata: task, ticks
//  apb      config  psel/penable/pwrite, pready  time_step at byte address 0
//
//  Tick: after accept the pointer is cleared, then each task is read, then evaluated and stamped;
//  a last step emits the final word. Register: entries with a lower prio are moved down, then
//  the new entry is inserted; a full table is refused; clear and reset all have a step each.
//  Tick evaluation and emitting steps wait while the output register is full and not taken.
//  Reset clears the table, time and tick count at once; no clearing pass is needed.
`default_nettype none

module periodic_task_dispatcher_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [47:0]                   s_tdata,  // task_id, task_period, task_priority
    input  wire logic [1:0]                    s_tuser,  // command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [39:0]                        m_tdata,  // task_out, ticks_done
    output logic [1:0]                         m_tuser,  // fired, status
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ptd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ptd_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import ptd_pkg::*;

    logic              accept;
    logic [STEP_W-1:0] time_step;
    ctl_t              ctl;
    flags_t            flags;
    logic              go;
    res_t              res;

    assign accept = s_tvalid && s_tready;

    ptd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .time_step (time_step)
    );

    ptd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .cmd      (cmd_t'(s_tuser)),
        .flags    (flags),
        .in_ready (s_tready),
        .ctl      (ctl),
        .go       (go)
    );

    ptd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_id     (s_tdata[7:0]),
        .in_period (s_tdata[38:8]),
        .in_prio   (s_tdata[46:39]),
        .time_step (time_step),
        .ctl       (ctl),
        .go        (go),
        .flags     (flags),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.ticks_done, res.task_out};
    assign m_tuser = {res.status, res.fired};
    assign m_tlast = res.last_of_run;

endmodule

`default_nettype wire

[rtl/ptd_checker.sv]
// Port-level checker for the dispatcher top level, with its bind
`default_nettype none

`include "assert_macros.svh"

module ptd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    `ASSERT_IMPLY(a_unfired_is_last, clk, rst_n, m_tvalid && !m_tuser[0], m_tlast, "word without a fired task must end its run")
    `ASSERT_IMPLY(a_refused_shape, clk, rst_n, m_tvalid && m_tuser[1], !m_tuser[0] && m_tlast, "refused registration must be a single unfired word")
    `ASSERT_IMPLY(a_busy_mid_run, clk, rst_n, m_tvalid && !m_tlast, !s_tready, "input taken before a dispatch run ended")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input ready again right after an accept")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
